FILE: design/mbrtu_pkg.sv
// shared constants, operation codes and crc helper for the modbus rtu receiver
package mbrtu_pkg;

   localparam int BUFFER_BYTES    = 64;
   localparam int MIN_FRAME_BYTES = 6;
   localparam int HEADER_BYTES    = 3;

   localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W        = CNT_W + 1;
   localparam int BANK_DEPTH   = BUFFER_BYTES / 2;
   localparam int ROW_W        = $clog2(BANK_DEPTH);
   localparam int BYTE_COUNT_W = 7;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_READ    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   // one byte of crc-16/modbus, reflected polynomial
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: design/mbrtu_ram.sv
// generic single write port ram with registered read
module mbrtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/modbus_rtu_frame_receiver.sv
// modbus rtu reply receiver: byte buffer, running crc-16 check, data word read
//
// Input channel (req_*): one word per accepted cycle carrying an operation:
// receive a byte, read a big-endian data word after the header, or restart
// the frame. Result channel (rsp_*): exactly one word per input word, in
// order, with the frame-ok flag, the byte count and, for reads, the data
// word and its valid bit. Configuration (csr_*): one register, the slave
// address, always ready; write it only while the block is idle.
// From acceptance a word passes the middle stage and the output register to
// rsp_valid: the buffer is held in two byte-wide rams (even and odd addresses)
// with registered reads, so a data word is fetched in one read, one byte from each bank.
// Throughput is one word per cycle while the output is not stalled; the crc update and frame check are one
// byte step of combinational logic on the accepting edge.
// Reset (synchronous) empties the buffer, clears the flag, loads the crc
// with all ones and sets the slave address to 1; the ram is not cleared.
// When rsp_stall is held, one more word is taken into the internal stage
// and then req_stall rises until the output drains.
module modbus_rtu_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic [4:0]  req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_ok,
   output logic [6:0]  rsp_byte_count,
   output logic [15:0] rsp_word_value,
   output logic        rsp_word_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int CW = mbrtu_pkg::CNT_W;
   localparam int PW = mbrtu_pkg::POS_W;
   localparam int RW = mbrtu_pkg::ROW_W;

   // frame state
   logic [CW-1:0] count_ff, count_in;
   logic          flag_ff, flag_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    last_ff, last_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    addr_ff;

   // middle stage, waiting for ram data
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ok_ff;
   logic [CW-1:0] s1_count_ff;
   logic          s1_wok_ff;
   logic          s1_hi_odd_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff;
   logic [CW-1:0] rsp_count_ff;
   logic [15:0]   rsp_value_ff;
   logic          rsp_wok_ff;

   logic          accept, s1_move, full, wok;
   logic          wr_en, rd_en;
   logic [PW-1:0] pos, pos1, cnt_ext, idx_ext;
   logic [RW-1:0] even_row, odd_row;
   logic [7:0]    even_data, odd_data;

   assign csr_ready = 1'b1;

   assign s1_move   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff >= CW'(mbrtu_pkg::BUFFER_BYTES);

   // read address and bounds
   assign idx_ext = PW'(req_word_index);
   assign cnt_ext = PW'(count_ff);
   assign pos     = PW'(mbrtu_pkg::HEADER_BYTES) + (idx_ext << 1);
   assign pos1    = pos + PW'(1);
   assign wok     = flag_ff
                    && cnt_ext >= PW'(mbrtu_pkg::HEADER_BYTES + 2)
                    && idx_ext < cnt_ext - PW'(mbrtu_pkg::HEADER_BYTES + 2)
                    && pos1 < cnt_ext
                    && pos1 < PW'(mbrtu_pkg::BUFFER_BYTES);
   assign even_row = pos[0] ? pos1[RW:1] : pos[RW:1];
   assign odd_row  = pos[0] ? pos[RW:1] : pos1[RW:1];

   assign wr_en = accept && (req_operation == mbrtu_pkg::OP_RECEIVE) && !full;
   assign rd_en = accept && (req_operation == mbrtu_pkg::OP_READ);

   always_comb begin
      count_in = count_ff;
      flag_in  = flag_ff;
      crc_in   = crc_ff;
      last_in  = last_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      if (accept) begin
         case (req_operation)
            mbrtu_pkg::OP_RECEIVE: begin
               if (!full) begin
                  if (count_ff >= CW'(2)) begin
                     crc_in = mbrtu_pkg::crc_fold(crc_ff, prev_ff);
                  end
                  prev_in  = last_ff;
                  last_in  = req_rx_byte;
                  if (count_ff == '0) begin
                     first_in = req_rx_byte;
                  end
                  count_in = count_ff + CW'(1);
               end
               // check repeats even when the byte was dropped
               if (count_in >= CW'(mbrtu_pkg::MIN_FRAME_BYTES)
                   && {last_in, prev_in} == crc_in && first_in == addr_ff) begin
                  flag_in = 1'b1;
               end
            end
            mbrtu_pkg::OP_RESTART: begin
               count_in = '0;
               flag_in  = 1'b0;
               crc_in   = mbrtu_pkg::CRC_INIT;
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = (s1_valid_ff && s1_move) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         crc_ff       <= mbrtu_pkg::CRC_INIT;
         addr_ff      <= 8'd1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         crc_ff       <= crc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            addr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      prev_ff  <= prev_in;
      first_ff <= first_in;
      if (accept) begin
         s1_ok_ff     <= flag_in;
         s1_count_ff  <= count_in;
         s1_wok_ff    <= rd_en && wok;
         s1_hi_odd_ff <= pos[0];
      end
      if (s1_valid_ff && s1_move) begin
         rsp_ok_ff    <= s1_ok_ff;
         rsp_count_ff <= s1_count_ff;
         rsp_wok_ff   <= s1_wok_ff;
         if (!s1_wok_ff) begin
            rsp_value_ff <= '0;
         end else if (s1_hi_odd_ff) begin
            rsp_value_ff <= {odd_data, even_data};
         end else begin
            rsp_value_ff <= {even_data, odd_data};
         end
      end
   end

   mbrtu_ram #(
      .WIDTH(8),
      .DEPTH(mbrtu_pkg::BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (wr_en && !count_ff[0]),
      .wr_addr (count_ff[RW:1]),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (even_row),
      .rd_data (even_data)
   );

   mbrtu_ram #(
      .WIDTH(8),
      .DEPTH(mbrtu_pkg::BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (wr_en && count_ff[0]),
      .wr_addr (count_ff[RW:1]),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (odd_row),
      .rd_data (odd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_ok   = rsp_ok_ff;
   assign rsp_byte_count = mbrtu_pkg::BYTE_COUNT_W'(rsp_count_ff);
   assign rsp_word_value = rsp_value_ff;
   assign rsp_word_valid = rsp_wok_ff;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == mbrtu_pkg::OP_RESTART |=> count_ff == '0 && !flag_ff)
      else $error("restart did not clear count and flag");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mbrtu_pkg::BUFFER_BYTES))
      else $error("byte count beyond buffer size");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      flag_ff && !(accept && req_operation == mbrtu_pkg::OP_RESTART) |=> flag_ff)
      else $error("frame flag dropped without restart");

   a_word_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wok_ff |-> rsp_ok_ff)
      else $error("word reported valid without a good frame");

   a_invalid_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_wok_ff |-> rsp_value_ff == '0)
      else $error("invalid word carries nonzero value");

endmodule
